@@ sv/msad_pkg.sv @@
// ----------------------------------------------------------------------------
// msad_pkg
// Types and fixed codes shared by the ModR/M / SIB address decode unit.
// ----------------------------------------------------------------------------
package msad_pkg;

	localparam int NUM_REGS   = 8;
	localparam int REG_W      = 32;
	localparam int REG_IDX_W  = 3;

	// item operation codes
	localparam logic OP_WRITE  = 1'b0;
	localparam logic OP_DECODE = 1'b1;

	// operand size codes (3 behaves as dword)
	localparam logic [1:0] SIZE_BYTE  = 2'd0;
	localparam logic [1:0] SIZE_WORD  = 2'd1;
	localparam logic [1:0] SIZE_DWORD = 2'd2;

	// mod field codes
	localparam logic [1:0] MOD_NO_DISP = 2'd0;
	localparam logic [1:0] MOD_DISP8   = 2'd1;
	localparam logic [1:0] MOD_DISP32  = 2'd2;
	localparam logic [1:0] MOD_REG     = 2'd3;

	// special register numbers
	localparam logic [REG_IDX_W-1:0] R_ESP = 3'd4;
	localparam logic [REG_IDX_W-1:0] R_EBP = 3'd5;

	// displacement byte counts
	localparam logic [2:0] DISP_NONE = 3'd0;
	localparam logic [2:0] DISP_ONE  = 3'd1;
	localparam logic [2:0] DISP_FOUR = 3'd4;

	typedef struct packed {
		logic        op;
		logic [7:0]  modrm;
		logic [7:0]  sib;
		logic [31:0] disp_raw;
		logic [1:0]  operand_size;
		logic        want_reg;
		logic        load_reg_value;
		logic        load_rm_value;
		logic [2:0]  write_index;
		logic [31:0] write_data;
	} msad_in_t;

	typedef struct packed {
		logic [2:0]  reg_field;
		logic [31:0] reg_value;
		logic        rm_is_memory;
		logic [2:0]  rm_index;
		logic [31:0] rm_value;
		logic [31:0] address;
		logic        has_sib;
		logic [2:0]  disp_bytes;
		logic [2:0]  bytes_used;
	} msad_out_t;

endpackage

@@ sv/msad_ram.sv @@
// ----------------------------------------------------------------------------
// msad_ram
// Generic RAM: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module msad_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
	input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
	output logic [WIDTH-1:0]         rd_data_a,
	output logic [WIDTH-1:0]         rd_data_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// read data holds while rd_en is low
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_a <= mem_q[rd_addr_a];
			rd_data_b <= mem_q[rd_addr_b];
		end
	end

endmodule

@@ sv/modrm_sib_address_decode_unit.sv @@
// ----------------------------------------------------------------------------
// modrm_sib_address_decode_unit
// 32-bit x86 ModR/M + SIB effective address decoder with an 8-entry GPR file.
// ----------------------------------------------------------------------------
// One item is taken per cycle unless the input stalls. The decode stage holds it
// after the transfer edge and the result register is loaded from the decode
// stage when it can take a new value; with no stall at the output the unit
// sustains one item per clock. A write
// item loads a general register at the edge it is taken, so every later item
// sees it. Register reads come from two copies of the 8x32 register file, each
// with two registered read ports: reg field, rm/base and index addresses are
// formed straight from the incoming item and read at the transfer edge. An
// 8-bit valid mask cleared by reset makes never-written registers read as
// zero, so no clearing pass is needed after reset. The decode stage forms
// disp + base + (index << scale) modulo 2^32 and the byte counts. A stalled
// result waits in the result register while the decode stage can still take
// one more item; only when both are full does the input stall.
module modrm_sib_address_decode_unit
	import msad_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	output logic      item_stall,
	input  msad_in_t  item,
	output logic      result_valid,
	input  logic      result_stall,
	output msad_out_t result
);

	// ---------------------------------------------------------------- control
	logic valid_s1;
	logic result_valid_s2;
	logic adv_s2;        // result register can take a new value
	logic adv_s1;        // decode stage hands its item on
	logic accept;        // input transfer this cycle

	assign adv_s2     = !result_valid_s2 || !result_stall;
	assign adv_s1     = valid_s1 && adv_s2;
	assign item_stall = valid_s1 && !adv_s1;
	assign accept     = item_valid && !item_stall;

	// ------------------------------------------------ read address formation
	logic                 wr_en;
	logic [REG_IDX_W-1:0] reg_addr;
	logic [REG_IDX_W-1:0] rmb_addr;
	logic [REG_IDX_W-1:0] idx_addr;
	logic                 in_byte;

	assign wr_en   = accept && (item.op == OP_WRITE);
	assign in_byte = (item.operand_size == SIZE_BYTE);

	always_comb begin
		// byte registers 4..7 are the high bytes of registers 0..3
		reg_addr = in_byte ? {1'b0, item.modrm[4:3]} : item.modrm[5:3];
		if (item.modrm[7:6] == MOD_REG) begin
			rmb_addr = in_byte ? {1'b0, item.modrm[1:0]} : item.modrm[2:0];
		end else if (item.modrm[2:0] == R_ESP) begin
			rmb_addr = item.sib[2:0];   // sib base
		end else begin
			rmb_addr = item.modrm[2:0];
		end
		idx_addr = item.sib[5:3];
	end

	// ----------------------------------------------------------- register file
	logic [REG_W-1:0]    reg_rd;
	logic [REG_W-1:0]    rmb_rd;
	logic [REG_W-1:0]    idx_rd;
	logic [NUM_REGS-1:0] reg_vld_q;

	// copy a serves the reg and rm/base ports, copy b the sib index port
	msad_ram #(
		.WIDTH (REG_W),
		.DEPTH (NUM_REGS)
	) u_gpr_a (
		.clk       (clk),
		.wr_en     (wr_en),
		.wr_addr   (item.write_index),
		.wr_data   (item.write_data),
		.rd_en     (accept),
		.rd_addr_a (reg_addr),
		.rd_addr_b (rmb_addr),
		.rd_data_a (reg_rd),
		.rd_data_b (rmb_rd)
	);

	msad_ram #(
		.WIDTH (REG_W),
		.DEPTH (NUM_REGS)
	) u_gpr_b (
		.clk       (clk),
		.wr_en     (wr_en),
		.wr_addr   (item.write_index),
		.wr_data   (item.write_data),
		.rd_en     (accept),
		.rd_addr_a (idx_addr),
		.rd_addr_b (idx_addr),
		.rd_data_a (idx_rd),
		.rd_data_b ()
	);

	// registers never written read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reg_vld_q <= '0;
		end else if (wr_en) begin
			reg_vld_q[item.write_index] <= 1'b1;
		end
	end

	// ------------------------------------------------------------ stage 1 regs
	msad_in_t item_s1;
	logic     reg_vld_s1;
	logic     rmb_vld_s1;
	logic     idx_vld_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1    <= item;
			reg_vld_s1 <= reg_vld_q[reg_addr];
			rmb_vld_s1 <= reg_vld_q[rmb_addr];
			idx_vld_s1 <= reg_vld_q[idx_addr];
		end
	end

	// ---------------------------------------------------------- decode stage
	// register value at operand width; hi_byte picks AH..BH in byte mode
	function automatic logic [REG_W-1:0] at_width(input logic [REG_W-1:0] data,
		input logic [1:0] size, input logic hi_byte);
		logic [REG_W-1:0] val;
		case (size)
			SIZE_BYTE: begin
				val = hi_byte ? {24'd0, data[15:8]} : {24'd0, data[7:0]};
			end
			SIZE_WORD: begin
				val = {16'd0, data[15:0]};
			end
			default: begin
				val = data;   // dword, and size code 3
			end
		endcase
		return val;
	endfunction

	logic [REG_W-1:0]     reg_data;
	logic [REG_W-1:0]     rmb_data;
	logic [REG_W-1:0]     idx_data;
	logic [1:0]           mod_f;
	logic [REG_IDX_W-1:0] reg_f;
	logic [REG_IDX_W-1:0] rm_f;
	logic [REG_IDX_W-1:0] base_f;
	logic                 use_base;
	logic                 use_index;
	logic [REG_W-1:0]     disp_val;
	logic [REG_W-1:0]     base_term;
	logic [REG_W-1:0]     index_term;
	msad_out_t            res_d;

	assign reg_data = reg_vld_s1 ? reg_rd : '0;
	assign rmb_data = rmb_vld_s1 ? rmb_rd : '0;
	assign idx_data = idx_vld_s1 ? idx_rd : '0;
	assign mod_f    = item_s1.modrm[7:6];
	assign reg_f    = item_s1.modrm[5:3];
	assign rm_f     = item_s1.modrm[2:0];

	always_comb begin
		res_d      = '0;
		base_f     = rm_f;
		use_base   = 1'b1;
		use_index  = 1'b0;
		disp_val   = '0;
		base_term  = '0;
		index_term = '0;

		if (item_s1.op == OP_DECODE) begin
			res_d.reg_field = reg_f;
			if (item_s1.want_reg && item_s1.load_reg_value) begin
				res_d.reg_value = at_width(reg_data, item_s1.operand_size, reg_f[2]);
			end

			if (mod_f == MOD_REG) begin
				// register form of r/m
				res_d.rm_index = rm_f;
				if (item_s1.load_rm_value) begin
					res_d.rm_value = at_width(rmb_data, item_s1.operand_size, rm_f[2]);
				end
			end else begin
				res_d.rm_is_memory = 1'b1;
				if (rm_f == R_ESP) begin
					res_d.has_sib = 1'b1;
					base_f        = item_s1.sib[2:0];
					use_index     = (item_s1.sib[5:3] != R_ESP);   // esp index: none
				end

				case (mod_f)
					MOD_NO_DISP: begin
						// ebp base without displacement means disp32 and no base register
						if (base_f == R_EBP) begin
							use_base         = 1'b0;
							res_d.disp_bytes = DISP_FOUR;
						end
					end
					MOD_DISP8: begin
						res_d.disp_bytes = DISP_ONE;
					end
					default: begin
						res_d.disp_bytes = DISP_FOUR;
					end
				endcase

				case (res_d.disp_bytes)
					DISP_ONE: begin
						disp_val = {{24{item_s1.disp_raw[7]}}, item_s1.disp_raw[7:0]};
					end
					DISP_FOUR: begin
						disp_val = item_s1.disp_raw;
					end
					default: begin
						disp_val = '0;
					end
				endcase

				if (use_base) begin
					base_term = rmb_data;
				end
				if (use_index) begin
					index_term = idx_data << item_s1.sib[7:6];
				end
				res_d.address = disp_val + base_term + index_term;
			end

			res_d.bytes_used = 3'd1 + {2'd0, res_d.has_sib} + res_d.disp_bytes;
		end
	end

	// --------------------------------------------------------- result register
	msad_out_t result_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			result_valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			result_s2 <= res_d;
		end
	end

	assign result_valid = result_valid_s2;
	assign result       = result_s2;

	// -------------------------------------------------------------- assertions
	// a taken write marks its register as written
	a_write_marks_valid: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (item.op == OP_WRITE) |=> reg_vld_q[$past(item.write_index)])
		else $error("write did not set register valid bit");

	// input side only stalls when both stages are occupied
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> valid_s1 && result_valid_s2)
		else $error("input stalled with room in the pipeline");

	// a new result only appears from an occupied decode stage
	a_result_from_s1: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_s2 && !$past(result_valid_s2) |-> $past(valid_s1))
		else $error("result appeared without a decoded item");

	// register form of r/m consumes no sib, no displacement and forms no address
	a_reg_form_clean: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.rm_is_memory |->
			!result.has_sib && (result.disp_bytes == DISP_NONE) && (result.address == '0))
		else $error("register r/m with memory addressing fields");

endmodule
